FILE: hdl/tam_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and codes for the telemetry anomaly monitor.
package tam_pkg;

    localparam int SEQ_W    = 64;
    localparam int TIME_W   = 64;
    localparam int POWER_W  = 32;
    localparam int LINK_W   = 8;
    localparam int REPLAY_W = 32;
    localparam int GAPS_W   = 32;
    localparam int RATE_W   = 20;
    localparam int LIMIT_W  = 32;
    localparam int PERIOD_W = 24;
    localparam int HANG_W   = PERIOD_W + 2;
    localparam int DELTA_W  = POWER_W + 1;
    localparam int DATA_W   = 32;
    localparam int ADDR_W   = 3;
    localparam int NUM_KINDS = 5;

    localparam logic [PERIOD_W-1:0] TICKS_PER_SEC = PERIOD_W'(10000000);
    localparam logic [RATE_W-1:0]   DEFAULT_RATE  = RATE_W'(10);
    localparam logic [LIMIT_W-1:0]  DEFAULT_LIMIT = LIMIT_W'(100000);
    localparam logic [PERIOD_W-1:0] RESET_PERIOD  = PERIOD_W'(1000000);
    localparam int DIV_STEPS = PERIOD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [POWER_W-1:0]  ABSENT32 = '1;
    localparam logic [REPLAY_W-1:0] ABSENT_REPLAY = '1;
    localparam logic [LINK_W-1:0]   ABSENT8  = '1;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Register indexes on the configuration port.
    localparam logic REG_RATE  = 1'b0;
    localparam logic REG_LIMIT = 1'b1;

    // Bit positions in the anomaly flag vector, in reporting order.
    localparam int FLAG_GAP    = 0;
    localparam int FLAG_HANG   = 1;
    localparam int FLAG_SPIKE  = 2;
    localparam int FLAG_LINK   = 3;
    localparam int FLAG_REPLAY = 4;

    typedef enum logic [2:0] {
        KIND_GAP    = 3'd0,
        KIND_HANG   = 3'd1,
        KIND_SPIKE  = 3'd2,
        KIND_LINK   = 3'd3,
        KIND_REPLAY = 3'd4
    } kind_t;

    // One classified record as it travels from the front to the back.
    typedef struct packed {
        logic [SEQ_W-1:0]     seq_now;
        logic [TIME_W-1:0]    interval_ticks;
        logic [NUM_KINDS-1:0] flags;
        logic [GAPS_W-1:0]    gap_number;
        logic [SEQ_W-1:0]     lost_count;
        logic [DELTA_W-1:0]   power_delta;
        logic [LINK_W-1:0]    gen_before;
        logic [LINK_W-1:0]    width_before;
        logic [LINK_W-1:0]    gen_now;
        logic [LINK_W-1:0]    width_now;
        logic [REPLAY_W-1:0]  replay_increase;
    } rec_t;

endpackage

FILE: hdl/tam_period_div.sv
`timescale 1ns / 1ps
// Restoring divider that turns the polling rate into the nominal period.
module tam_period_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [tam_pkg::RATE_W-1:0]    rate,
    output logic                          busy,
    output logic [tam_pkg::PERIOD_W-1:0]  period
);

    logic                           busy_reg, busy_next;
    logic [tam_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [tam_pkg::RATE_W-1:0]     divisor_reg, divisor_next;
    logic [tam_pkg::RATE_W-1:0]     rem_reg, rem_next;
    logic [tam_pkg::PERIOD_W-1:0]   dq_reg, dq_next;
    logic [tam_pkg::PERIOD_W-1:0]   period_reg, period_next;
    logic [tam_pkg::RATE_W:0]       rem_shift;
    logic [tam_pkg::RATE_W:0]       rem_sub;
    logic                           fits;
    logic                           last_step;

    // One quotient bit per cycle: shift in the next dividend bit, subtract if it fits.
    always_comb
    begin
        rem_shift = {rem_reg, dq_reg[tam_pkg::PERIOD_W-1]};
        rem_sub   = rem_shift - {1'b0, divisor_reg};
        fits      = (rem_shift >= {1'b0, divisor_reg});
        last_step = (cnt_reg == tam_pkg::DIV_CNT_W'(tam_pkg::DIV_STEPS - 1));
    end

    always_comb
    begin
        busy_next    = busy_reg;
        cnt_next     = cnt_reg;
        divisor_next = divisor_reg;
        rem_next     = rem_reg;
        dq_next      = dq_reg;
        period_next  = period_reg;
        if (start)
        begin
            busy_next    = 1'b1;
            cnt_next     = '0;
            divisor_next = (rate == '0) ? tam_pkg::DEFAULT_RATE : rate;
            rem_next     = '0;
            dq_next      = tam_pkg::TICKS_PER_SEC;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? rem_sub[tam_pkg::RATE_W-1:0] : rem_shift[tam_pkg::RATE_W-1:0];
            dq_next  = {dq_reg[tam_pkg::PERIOD_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (last_step)
            begin
                busy_next   = 1'b0;
                period_next = {dq_reg[tam_pkg::PERIOD_W-2:0], fits};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            cnt_reg    <= '0;
            period_reg <= tam_pkg::RESET_PERIOD;
        end
        else
        begin
            busy_reg   <= busy_next;
            cnt_reg    <= cnt_next;
            period_reg <= period_next;
        end
    end

    always_ff @(posedge clk)
    begin
        divisor_reg <= divisor_next;
        rem_reg     <= rem_next;
        dq_reg      <= dq_next;
    end

    assign busy   = busy_reg;
    assign period = period_reg;

endmodule

FILE: hdl/tam_front.sv
`timescale 1ns / 1ps
// Front part: compares each accepted record with the previous one and flags anomalies.
module tam_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          take,
    input  logic                          starts_scan,
    input  logic [tam_pkg::SEQ_W-1:0]     seq_number,
    input  logic [tam_pkg::TIME_W-1:0]    time_ticks,
    input  logic                          is_data,
    input  logic [tam_pkg::POWER_W-1:0]   power_mw,
    input  logic [tam_pkg::LINK_W-1:0]    link_gen,
    input  logic [tam_pkg::LINK_W-1:0]    link_width,
    input  logic [tam_pkg::REPLAY_W-1:0]  replay_total,
    input  logic [tam_pkg::PERIOD_W-1:0]  period,
    input  logic [tam_pkg::LIMIT_W-1:0]   power_limit,
    output logic                          rec_valid,
    output tam_pkg::rec_t                 rec
);

    logic                          have_prev_reg, have_prev_next;
    logic [tam_pkg::GAPS_W-1:0]    gaps_reg, gaps_next;
    logic [tam_pkg::SEQ_W-1:0]     prev_seq_reg;
    logic [tam_pkg::TIME_W-1:0]    prev_time_reg;
    logic                          prev_data_reg;
    logic [tam_pkg::POWER_W-1:0]   prev_power_reg;
    logic [tam_pkg::LINK_W-1:0]    prev_gen_reg;
    logic [tam_pkg::LINK_W-1:0]    prev_width_reg;
    logic [tam_pkg::REPLAY_W-1:0]  prev_replay_reg;

    logic                          compare_ok;
    logic                          data_ok;
    logic [tam_pkg::SEQ_W:0]       seq_diff;
    logic [tam_pkg::TIME_W:0]      time_diff;
    logic [tam_pkg::HANG_W-1:0]    hang_limit;
    logic [tam_pkg::DELTA_W-1:0]   pw_diff;
    logic [tam_pkg::POWER_W-1:0]   pw_back;
    logic [tam_pkg::POWER_W-1:0]   pw_mag;
    logic                          gap_hit, hang_hit, spike_hit, link_hit, replay_hit;

    always_comb
    begin
        compare_ok = have_prev_reg && !starts_scan;
        data_ok    = compare_ok && is_data && prev_data_reg;

        // seq - prev - 1, kept one bit wider so that a backward step shows as a borrow.
        seq_diff = {1'b0, seq_number} - {1'b0, prev_seq_reg} - {{tam_pkg::SEQ_W{1'b0}}, 1'b1};
        gap_hit  = compare_ok && !seq_diff[tam_pkg::SEQ_W] && (seq_diff[tam_pkg::SEQ_W-1:0] != '0);

        time_diff  = {1'b0, time_ticks} - {1'b0, prev_time_reg};
        hang_limit = {2'b00, period} + {1'b0, period, 1'b0};
        hang_hit   = compare_ok && !time_diff[tam_pkg::TIME_W] &&
                     (time_diff[tam_pkg::TIME_W-1:0] >
                      {{(tam_pkg::TIME_W - tam_pkg::HANG_W){1'b0}}, hang_limit});

        pw_diff   = {1'b0, power_mw} - {1'b0, prev_power_reg};
        pw_back   = prev_power_reg - power_mw;
        pw_mag    = pw_diff[tam_pkg::POWER_W] ? pw_back : pw_diff[tam_pkg::POWER_W-1:0];
        spike_hit = data_ok && (power_mw != tam_pkg::ABSENT32) &&
                    (prev_power_reg != tam_pkg::ABSENT32) && (pw_mag > power_limit);

        link_hit = data_ok && (link_gen != tam_pkg::ABSENT8) && (link_width != tam_pkg::ABSENT8) &&
                   (prev_gen_reg != tam_pkg::ABSENT8) && (prev_width_reg != tam_pkg::ABSENT8) &&
                   ((link_gen < prev_gen_reg) || (link_width < prev_width_reg));

        replay_hit = data_ok && (replay_total != tam_pkg::ABSENT_REPLAY) &&
                     (prev_replay_reg != tam_pkg::ABSENT_REPLAY) &&
                     (replay_total > prev_replay_reg);
    end

    always_comb
    begin
        rec = '0;
        rec.seq_now        = seq_number;
        rec.interval_ticks = time_diff[tam_pkg::TIME_W] ? '0 : time_diff[tam_pkg::TIME_W-1:0];
        rec.flags[tam_pkg::FLAG_GAP]    = gap_hit;
        rec.flags[tam_pkg::FLAG_HANG]   = hang_hit;
        rec.flags[tam_pkg::FLAG_SPIKE]  = spike_hit;
        rec.flags[tam_pkg::FLAG_LINK]   = link_hit;
        rec.flags[tam_pkg::FLAG_REPLAY] = replay_hit;
        rec.gap_number      = gaps_reg + 1'b1;
        rec.lost_count      = seq_diff[tam_pkg::SEQ_W-1:0];
        rec.power_delta     = pw_diff;
        rec.gen_before      = prev_gen_reg;
        rec.width_before    = prev_width_reg;
        rec.gen_now         = link_gen;
        rec.width_now       = link_width;
        rec.replay_increase = replay_total - prev_replay_reg;
        // Records without any anomaly never enter the queue.
        rec_valid = take && (rec.flags != '0);
    end

    always_comb
    begin
        have_prev_next = have_prev_reg;
        gaps_next      = gaps_reg;
        if (take)
        begin
            have_prev_next = 1'b1;
            if (starts_scan)
            begin
                gaps_next = '0;
            end
            else if (gap_hit)
            begin
                gaps_next = gaps_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            gaps_reg      <= '0;
        end
        else
        begin
            have_prev_reg <= have_prev_next;
            gaps_reg      <= gaps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            prev_seq_reg    <= seq_number;
            prev_time_reg   <= time_ticks;
            prev_data_reg   <= is_data;
            prev_power_reg  <= power_mw;
            prev_gen_reg    <= link_gen;
            prev_width_reg  <= link_width;
            prev_replay_reg <= replay_total;
        end
    end

endmodule

FILE: hdl/tam_queue.sv
`timescale 1ns / 1ps
// Small register queue that decouples the front from the back.
module tam_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    always_comb
    begin
        do_wr = wr_en && (count_reg != CNT_W'(DEPTH));
        do_rd = rd_en && (count_reg != '0);
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(do_wr) - CNT_W'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    assign rd_data = mem_reg[rd_ptr_reg];
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);

endmodule

FILE: hdl/tam_back.sv
`timescale 1ns / 1ps
// Back part: expands each queued record into its results, one per cycle while they are popped.
module tam_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  tam_pkg::rec_t                 q_rec,
    output logic                          q_pop,
    input  logic                          pop,
    output logic                          empty,
    output logic [2:0]                    kind,
    output logic [tam_pkg::SEQ_W-1:0]     seq_now,
    output logic [tam_pkg::GAPS_W-1:0]    gap_number,
    output logic [tam_pkg::SEQ_W-1:0]     lost_count,
    output logic [tam_pkg::TIME_W-1:0]    interval_ticks,
    output logic [tam_pkg::DELTA_W-1:0]   power_delta,
    output logic [tam_pkg::LINK_W-1:0]    gen_before,
    output logic [tam_pkg::LINK_W-1:0]    width_before,
    output logic [tam_pkg::LINK_W-1:0]    gen_now,
    output logic [tam_pkg::LINK_W-1:0]    width_now,
    output logic [tam_pkg::REPLAY_W-1:0]  replay_increase,
    output logic                          last
);

    logic                           out_valid_reg, out_valid_next;
    logic [tam_pkg::NUM_KINDS-1:0]  done_reg, done_next;
    logic [tam_pkg::NUM_KINDS-1:0]  remaining;
    logic [tam_pkg::NUM_KINDS-1:0]  cur_bit;
    tam_pkg::kind_t                 cur_kind;
    logic                           is_last;
    logic                           advance;

    tam_pkg::kind_t                 kind_reg;
    logic [tam_pkg::SEQ_W-1:0]      seq_reg;
    logic [tam_pkg::GAPS_W-1:0]     gap_reg;
    logic [tam_pkg::SEQ_W-1:0]      lost_reg;
    logic [tam_pkg::TIME_W-1:0]     interval_reg;
    logic [tam_pkg::DELTA_W-1:0]    delta_reg;
    logic [tam_pkg::LINK_W-1:0]     gen_before_reg, width_before_reg;
    logic [tam_pkg::LINK_W-1:0]     gen_now_reg, width_now_reg;
    logic [tam_pkg::REPLAY_W-1:0]   replay_reg;
    logic                           last_reg;

    // The lowest pending flag of the head record is the next result.
    always_comb
    begin
        remaining = q_rec.flags & ~done_reg;
        cur_bit   = '0;
        priority if (remaining[tam_pkg::FLAG_GAP])
        begin
            cur_kind = tam_pkg::KIND_GAP;
            cur_bit[tam_pkg::FLAG_GAP] = 1'b1;
        end
        else if (remaining[tam_pkg::FLAG_HANG])
        begin
            cur_kind = tam_pkg::KIND_HANG;
            cur_bit[tam_pkg::FLAG_HANG] = 1'b1;
        end
        else if (remaining[tam_pkg::FLAG_SPIKE])
        begin
            cur_kind = tam_pkg::KIND_SPIKE;
            cur_bit[tam_pkg::FLAG_SPIKE] = 1'b1;
        end
        else if (remaining[tam_pkg::FLAG_LINK])
        begin
            cur_kind = tam_pkg::KIND_LINK;
            cur_bit[tam_pkg::FLAG_LINK] = 1'b1;
        end
        else
        begin
            cur_kind = tam_pkg::KIND_REPLAY;
            cur_bit[tam_pkg::FLAG_REPLAY] = 1'b1;
        end
        is_last = ((remaining & ~cur_bit) == '0);
        advance = !q_empty && (!out_valid_reg || pop);
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        done_next      = done_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
            done_next      = is_last ? '0 : (done_reg | cur_bit);
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            done_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            kind_reg         <= cur_kind;
            seq_reg          <= q_rec.seq_now;
            interval_reg     <= q_rec.interval_ticks;
            gap_reg          <= (cur_kind == tam_pkg::KIND_GAP) ? q_rec.gap_number : '0;
            lost_reg         <= (cur_kind == tam_pkg::KIND_GAP) ? q_rec.lost_count : '0;
            delta_reg        <= (cur_kind == tam_pkg::KIND_SPIKE) ? q_rec.power_delta : '0;
            gen_before_reg   <= (cur_kind == tam_pkg::KIND_LINK) ? q_rec.gen_before : '0;
            width_before_reg <= (cur_kind == tam_pkg::KIND_LINK) ? q_rec.width_before : '0;
            gen_now_reg      <= (cur_kind == tam_pkg::KIND_LINK) ? q_rec.gen_now : '0;
            width_now_reg    <= (cur_kind == tam_pkg::KIND_LINK) ? q_rec.width_now : '0;
            replay_reg       <= (cur_kind == tam_pkg::KIND_REPLAY) ? q_rec.replay_increase : '0;
            last_reg         <= is_last;
        end
    end

    assign q_pop           = advance && is_last;
    assign empty           = !out_valid_reg;
    assign kind            = kind_reg;
    assign seq_now         = seq_reg;
    assign gap_number      = gap_reg;
    assign lost_count      = lost_reg;
    assign interval_ticks  = interval_reg;
    assign power_delta     = delta_reg;
    assign gen_before      = gen_before_reg;
    assign width_before    = width_before_reg;
    assign gen_now         = gen_now_reg;
    assign width_now       = width_now_reg;
    assign replay_increase = replay_reg;
    assign last            = last_reg;

endmodule

FILE: hdl/telemetry_anomaly_monitor_unit.sv
`timescale 1ns / 1ps
// Top level of the telemetry anomaly monitor: configuration, front, queue, back.
//
//   Channel   Handshake              Payload
//   -------   --------------------   ------------------------------------------------
//   config    psel/penable/pready    paddr, pwdata, prdata (rate at 0x0, limit at 0x4)
//   records   push / full            starts_scan, seq_number, ... replay_total
//   results   empty / pop            kind, seq_now, ... replay_increase, last
//
// A record is classified in the cycle of its transfer, so one record can be taken
// every cycle while full is low. Its results leave through the single result port
// one per cycle while they are popped, so a record with n anomalies yields n results
// (none when n is zero). Writing the rate register starts a restoring division;
// full stays high until the new period is ready. Reset is asynchronous and active
// low; it empties the queue and the output register and forgets the previous record.
module telemetry_anomaly_monitor_unit #(
    parameter int QUEUE_DEPTH = tam_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Configuration port.
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tam_pkg::ADDR_W-1:0]           paddr,
    input  logic [tam_pkg::DATA_W-1:0]           pwdata,
    output logic [tam_pkg::DATA_W-1:0]           prdata,
    output logic                                 pready,
    // Record input.
    input  logic                                 push,
    output logic                                 full,
    input  logic                                 starts_scan,
    input  logic [tam_pkg::SEQ_W-1:0]            seq_number,
    input  logic [tam_pkg::TIME_W-1:0]           time_ticks,
    input  logic                                 is_data,
    input  logic [tam_pkg::POWER_W-1:0]          power_mw,
    input  logic [tam_pkg::LINK_W-1:0]           link_gen,
    input  logic [tam_pkg::LINK_W-1:0]           link_width,
    input  logic [tam_pkg::REPLAY_W-1:0]         replay_total,
    // Result output.
    output logic                                 empty,
    input  logic                                 pop,
    output logic [2:0]                           kind,
    output logic [tam_pkg::SEQ_W-1:0]            seq_now,
    output logic [tam_pkg::GAPS_W-1:0]           gap_number,
    output logic [tam_pkg::SEQ_W-1:0]            lost_count,
    output logic [tam_pkg::TIME_W-1:0]           interval_ticks,
    output logic signed [tam_pkg::DELTA_W-1:0]   power_delta_mw,
    output logic [tam_pkg::LINK_W-1:0]           gen_before,
    output logic [tam_pkg::LINK_W-1:0]           width_before,
    output logic [tam_pkg::LINK_W-1:0]           gen_now,
    output logic [tam_pkg::LINK_W-1:0]           width_now,
    output logic [tam_pkg::REPLAY_W-1:0]         replay_increase,
    output logic                                 last
);

    logic [tam_pkg::RATE_W-1:0]   rate_reg, rate_next;
    logic [tam_pkg::LIMIT_W-1:0]  limit_reg, limit_next;
    logic                         cfg_write;
    logic                         rate_write;
    logic                         div_busy;
    logic [tam_pkg::PERIOD_W-1:0] period;

    logic                         take;
    logic                         rec_valid;
    tam_pkg::rec_t                front_rec;
    tam_pkg::rec_t                head_rec;
    logic                         q_full, q_empty, q_pop;
    logic [tam_pkg::DELTA_W-1:0]  power_delta;

    // The register is written in the access phase of a write transfer.
    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign rate_write = cfg_write && (paddr[2] == tam_pkg::REG_RATE);

    always_comb
    begin
        rate_next  = rate_reg;
        limit_next = limit_reg;
        if (cfg_write)
        begin
            unique case (paddr[2])
                tam_pkg::REG_RATE:  rate_next  = pwdata[tam_pkg::RATE_W-1:0];
                tam_pkg::REG_LIMIT: limit_next = pwdata[tam_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            tam_pkg::REG_RATE:
                prdata = {{(tam_pkg::DATA_W - tam_pkg::RATE_W){1'b0}}, rate_reg};
            tam_pkg::REG_LIMIT:
                prdata = limit_reg;
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg  <= tam_pkg::DEFAULT_RATE;
            limit_reg <= tam_pkg::DEFAULT_LIMIT;
        end
        else
        begin
            rate_reg  <= rate_next;
            limit_reg <= limit_next;
        end
    end

    // The period is recomputed after every rate write; records wait meanwhile.
    tam_period_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (rate_write),
        .rate   (pwdata[tam_pkg::RATE_W-1:0]),
        .busy   (div_busy),
        .period (period)
    );

    assign full = q_full || div_busy;
    assign take = push && !full;

    tam_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .take         (take),
        .starts_scan  (starts_scan),
        .seq_number   (seq_number),
        .time_ticks   (time_ticks),
        .is_data      (is_data),
        .power_mw     (power_mw),
        .link_gen     (link_gen),
        .link_width   (link_width),
        .replay_total (replay_total),
        .period       (period),
        .power_limit  (limit_reg),
        .rec_valid    (rec_valid),
        .rec          (front_rec)
    );

    tam_queue #(
        .WIDTH ($bits(tam_pkg::rec_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (rec_valid),
        .wr_data (front_rec),
        .rd_en   (q_pop),
        .rd_data (head_rec),
        .full    (q_full),
        .empty   (q_empty)
    );

    tam_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .q_rec           (head_rec),
        .q_pop           (q_pop),
        .pop             (pop),
        .empty           (empty),
        .kind            (kind),
        .seq_now         (seq_now),
        .gap_number      (gap_number),
        .lost_count      (lost_count),
        .interval_ticks  (interval_ticks),
        .power_delta     (power_delta),
        .gen_before      (gen_before),
        .width_before    (width_before),
        .gen_now         (gen_now),
        .width_now       (width_now),
        .replay_increase (replay_increase),
        .last            (last)
    );

    assign power_delta_mw = $signed(power_delta);

endmodule

FILE: hdl/tam_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the telemetry anomaly monitor, bound to the top level.
module tam_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [tam_pkg::ADDR_W-1:0]           paddr,
    input  logic                                 pready,
    input  logic                                 full,
    input  logic                                 empty,
    input  logic                                 pop,
    input  logic [2:0]                           kind,
    input  logic [tam_pkg::SEQ_W-1:0]            seq_now,
    input  logic [tam_pkg::GAPS_W-1:0]           gap_number,
    input  logic [tam_pkg::SEQ_W-1:0]            lost_count,
    input  logic                                 last
);

    // A waiting result holds until it is taken.
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(kind) && $stable(seq_now)))
        else $error("result changed while waiting");

    // Results of one record follow back to back, in rising kind order.
    a_record_burst: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last) |=>
            (!empty && (kind > $past(kind)) && (seq_now == $past(seq_now))))
        else $error("results of one record broken up or out of order");

    // Gap fields are zero on every other kind.
    a_gap_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (kind != tam_pkg::KIND_GAP)) |-> ((gap_number == '0) && (lost_count == '0)))
        else $error("gap fields set on a non-gap result");

    // A rate write holds off records while the period is recomputed.
    a_rate_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && pready && (paddr[2] == tam_pkg::REG_RATE)) |=> full)
        else $error("records accepted during period update");

endmodule

bind telemetry_anomaly_monitor_unit tam_checker u_tam_checker (.*);

FILE: tb/telemetry_anomaly_monitor_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the telemetry anomaly monitor with a built-in predictor.
module telemetry_anomaly_monitor_unit_tb;

    import tam_pkg::*;

    // Cycles allowed for the block to settle before a register write and at the end.
    // This also covers the period division that follows a rate write.
    localparam int SETTLE_CYCLES   = 40;
    localparam int HANG_FACTOR     = 3;
    localparam int IDLE_PCT        = 24;
    localparam int NUM_PHASES      = 5;
    localparam int ITEMS_PER_PHASE = 96;
    // Window of accepted records during which neither side idles.
    localparam int CALM_FIRST      = 300;
    localparam int CALM_LAST       = 380;
    localparam int MAX_REPORTS     = 60;

    localparam logic [ADDR_W-1:0] RATE_ADDR  = {REG_RATE, 2'b00};
    localparam logic [ADDR_W-1:0] LIMIT_ADDR = {REG_LIMIT, 2'b00};

    // One telemetry record as it is offered to the block.
    typedef struct {
        logic                starts_scan;
        logic [SEQ_W-1:0]    seq_number;
        logic [TIME_W-1:0]   time_ticks;
        logic                is_data;
        logic [POWER_W-1:0]  power_mw;
        logic [LINK_W-1:0]   link_gen;
        logic [LINK_W-1:0]   link_width;
        logic [REPLAY_W-1:0] replay_total;
    } telemetry_rec_t;

    // One anomaly report as the block should present it.
    typedef struct {
        kind_t                      kind;
        logic [SEQ_W-1:0]           seq_now;
        logic [GAPS_W-1:0]          gap_number;
        logic [SEQ_W-1:0]           lost_count;
        logic [TIME_W-1:0]          interval_ticks;
        logic signed [DELTA_W-1:0]  power_delta;
        logic [LINK_W-1:0]          gen_before;
        logic [LINK_W-1:0]          width_before;
        logic [LINK_W-1:0]          gen_now;
        logic [LINK_W-1:0]          width_now;
        logic [REPLAY_W-1:0]        replay_increase;
        logic                       last;
    } anomaly_t;

    logic                        clk = 1'b0;
    logic                        rst_n = 1'b0;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [ADDR_W-1:0]           paddr = '0;
    logic [DATA_W-1:0]           pwdata = '0;
    logic [DATA_W-1:0]           prdata;
    logic                        pready;
    logic                        push = 1'b0;
    logic                        full;
    logic                        starts_scan = 1'b0;
    logic [SEQ_W-1:0]            seq_number = '0;
    logic [TIME_W-1:0]           time_ticks = '0;
    logic                        is_data = 1'b0;
    logic [POWER_W-1:0]          power_mw = '0;
    logic [LINK_W-1:0]           link_gen = '0;
    logic [LINK_W-1:0]           link_width = '0;
    logic [REPLAY_W-1:0]         replay_total = '0;
    logic                        empty;
    logic                        pop = 1'b0;
    logic [2:0]                  kind;
    logic [SEQ_W-1:0]            seq_now;
    logic [GAPS_W-1:0]           gap_number;
    logic [SEQ_W-1:0]            lost_count;
    logic [TIME_W-1:0]           interval_ticks;
    logic signed [DELTA_W-1:0]   power_delta_mw;
    logic [LINK_W-1:0]           gen_before;
    logic [LINK_W-1:0]           width_before;
    logic [LINK_W-1:0]           gen_now;
    logic [LINK_W-1:0]           width_now;
    logic [REPLAY_W-1:0]         replay_increase;
    logic                        last;

    telemetry_anomaly_monitor_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .push            (push),
        .full            (full),
        .starts_scan     (starts_scan),
        .seq_number      (seq_number),
        .time_ticks      (time_ticks),
        .is_data         (is_data),
        .power_mw        (power_mw),
        .link_gen        (link_gen),
        .link_width      (link_width),
        .replay_total    (replay_total),
        .empty           (empty),
        .pop             (pop),
        .kind            (kind),
        .seq_now         (seq_now),
        .gap_number      (gap_number),
        .lost_count      (lost_count),
        .interval_ticks  (interval_ticks),
        .power_delta_mw  (power_delta_mw),
        .gen_before      (gen_before),
        .width_before    (width_before),
        .gen_now         (gen_now),
        .width_now       (width_now),
        .replay_increase (replay_increase),
        .last            (last)
    );

    // 8 ns clock period.
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Records waiting to be offered, and anomaly reports still owed by the block.
    telemetry_rec_t record_backlog [$];
    anomaly_t       expected_anomalies [$];
    telemetry_rec_t next_rec;

    int   errors = 0;
    int   records_taken = 0;
    logic rec_taken = 1'b0;
    logic calm;

    assign calm = (records_taken >= CALM_FIRST) && (records_taken < CALM_LAST);

    // Predictor copy of the configuration and of the remembered record.
    logic [RATE_W-1:0]   rate_hz = DEFAULT_RATE;
    logic [LIMIT_W-1:0]  spike_limit = DEFAULT_LIMIT;
    logic [PERIOD_W-1:0] period_ticks = RESET_PERIOD;
    logic                have_last = 1'b0;
    logic [SEQ_W-1:0]    last_seq = '0;
    logic [TIME_W-1:0]   last_time = '0;
    logic                last_is_data = 1'b0;
    logic [POWER_W-1:0]  last_power = '0;
    logic [LINK_W-1:0]   last_gen = '0;
    logic [LINK_W-1:0]   last_width = '0;
    logic [REPLAY_W-1:0] last_replay = '0;
    logic [GAPS_W-1:0]   gap_total = '0;

    // The stimulus generator keeps the last record it queued so that the random part can
    // build well-formed sequences on top of it.
    logic [SEQ_W-1:0]    stim_seq = '0;
    logic [TIME_W-1:0]   stim_time = '0;
    logic [POWER_W-1:0]  stim_power = '0;
    logic [LINK_W-1:0]   stim_gen = '0;
    logic [LINK_W-1:0]   stim_width = '0;
    logic [REPLAY_W-1:0] stim_replay = '0;

    // An empty report of the given kind; every kind carries the sequence number and the
    // interval, the remaining fields are filled in by the caller.
    function automatic anomaly_t blank_anomaly(input kind_t k, input logic [SEQ_W-1:0] seq,
                                               input logic [TIME_W-1:0] span);
        anomaly_t a;
        a = '{kind: k, seq_now: seq, interval_ticks: span, default: '0};
        return a;
    endfunction

    // Classify one accepted record against the remembered one and queue its reports in
    // reporting order: gap, hang, power spike, link drop, replay jump.
    task automatic classify_record(input telemetry_rec_t rec);
        anomaly_t           found [$];
        anomaly_t           a;
        logic [TIME_W-1:0]  span;
        logic [POWER_W-1:0] swing;
        if (rec.starts_scan)
        begin
            have_last = 1'b0;
            gap_total = '0;
        end
        if (have_last)
        begin
            span = (rec.time_ticks >= last_time) ? rec.time_ticks - last_time : '0;
            // A gap needs the new number to be ahead by more than one, without wrap.
            if (rec.seq_number > last_seq && rec.seq_number - last_seq > 1)
            begin
                gap_total = gap_total + 1'b1;
                a = blank_anomaly(KIND_GAP, rec.seq_number, span);
                a.gap_number = gap_total;
                a.lost_count = rec.seq_number - last_seq - 1;
                found.push_back(a);
            end
            if (rec.time_ticks > last_time &&
                span > TIME_W'(period_ticks) * TIME_W'(HANG_FACTOR))
                found.push_back(blank_anomaly(KIND_HANG, rec.seq_number, span));
            // The remaining checks compare two data records with values present.
            if (rec.is_data && last_is_data)
            begin
                if (rec.power_mw != ABSENT32 && last_power != ABSENT32)
                begin
                    swing = (rec.power_mw >= last_power) ? rec.power_mw - last_power
                                                         : last_power - rec.power_mw;
                    if (swing > spike_limit)
                    begin
                        a = blank_anomaly(KIND_SPIKE, rec.seq_number, span);
                        a.power_delta = {1'b0, rec.power_mw} - {1'b0, last_power};
                        found.push_back(a);
                    end
                end
                if (rec.link_gen != ABSENT8 && rec.link_width != ABSENT8 &&
                    last_gen != ABSENT8 && last_width != ABSENT8 &&
                    (rec.link_gen < last_gen || rec.link_width < last_width))
                begin
                    a = blank_anomaly(KIND_LINK, rec.seq_number, span);
                    a.gen_before = last_gen;
                    a.width_before = last_width;
                    a.gen_now = rec.link_gen;
                    a.width_now = rec.link_width;
                    found.push_back(a);
                end
                if (rec.replay_total != ABSENT_REPLAY && last_replay != ABSENT_REPLAY &&
                    rec.replay_total > last_replay)
                begin
                    a = blank_anomaly(KIND_REPLAY, rec.seq_number, span);
                    a.replay_increase = rec.replay_total - last_replay;
                    found.push_back(a);
                end
            end
            if (found.size() > 0)
                found[found.size() - 1].last = 1'b1;
            foreach (found[i])
                expected_anomalies.push_back(found[i]);
        end
        // Every record, anomalous or not, becomes the one to compare against next.
        have_last = 1'b1;
        last_seq = rec.seq_number;
        last_time = rec.time_ticks;
        last_is_data = rec.is_data;
        last_power = rec.power_mw;
        last_gen = rec.link_gen;
        last_width = rec.link_width;
        last_replay = rec.replay_total;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
                         $time, name, want, got);
        end
    endtask

    // Compare the report just transferred with the oldest one still owed.
    task automatic check_result();
        anomaly_t want;
        if (expected_anomalies.size() == 0)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns: unexpected report, expected none, got kind %0d seq 0x%0h",
                         $time, kind, seq_now);
        end
        else
        begin
            want = expected_anomalies.pop_front();
            check_field("kind", 64'(want.kind), 64'(kind));
            check_field("seq_now", want.seq_now, seq_now);
            check_field("gap_number", 64'(want.gap_number), 64'(gap_number));
            check_field("lost_count", want.lost_count, lost_count);
            check_field("interval_ticks", want.interval_ticks, interval_ticks);
            check_field("power_delta_mw", 64'(want.power_delta), 64'(power_delta_mw));
            check_field("gen_before", 64'(want.gen_before), 64'(gen_before));
            check_field("width_before", 64'(want.width_before), 64'(width_before));
            check_field("gen_now", 64'(want.gen_now), 64'(gen_now));
            check_field("width_now", 64'(want.width_now), 64'(width_now));
            check_field("replay_increase", 64'(want.replay_increase),
                        64'(replay_increase));
            check_field("last", 64'(want.last), 64'(last));
        end
    endtask

    // Everything that happens at a rising edge: register writes seen by the predictor,
    // record transfers fed to the predictor, and report transfers checked against it.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == RATE_ADDR)
                begin
                    rate_hz = pwdata[RATE_W-1:0];
                    // A rate of zero stands for the default rate.
                    period_ticks = PERIOD_W'(TICKS_PER_SEC /
                                             ((rate_hz != '0) ? rate_hz : DEFAULT_RATE));
                end
                else if (paddr == LIMIT_ADDR)
                    spike_limit = pwdata[LIMIT_W-1:0];
            end
            if (push && !full)
            begin
                classify_record('{starts_scan, seq_number, time_ticks, is_data, power_mw,
                                  link_gen, link_width, replay_total});
                records_taken++;
            end
            rec_taken <= push && !full;
            if (pop && !empty)
                check_result();
        end
    end

    // Record driver. A new record is offered only once the previous one has been taken,
    // and push may drop at random between records to open gaps on the input side.
    always @(negedge clk)
    begin
        if (rst_n && (!push || rec_taken))
        begin
            if (record_backlog.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT))
            begin
                next_rec = record_backlog.pop_front();
                starts_scan  <= next_rec.starts_scan;
                seq_number   <= next_rec.seq_number;
                time_ticks   <= next_rec.time_ticks;
                is_data      <= next_rec.is_data;
                power_mw     <= next_rec.power_mw;
                link_gen     <= next_rec.link_gen;
                link_width   <= next_rec.link_width;
                replay_total <= next_rec.replay_total;
                push         <= 1'b1;
            end
            else
                push <= 1'b0;
        end
    end

    // Report consumer: stalls at random except inside the calm window.
    always @(negedge clk)
        pop <= rst_n && (calm || $urandom_range(99) >= IDLE_PCT);

    task automatic add_rec(input logic start, input logic [SEQ_W-1:0] seq,
                           input logic [TIME_W-1:0] t, input logic data,
                           input logic [POWER_W-1:0] pw, input logic [LINK_W-1:0] gen,
                           input logic [LINK_W-1:0] wid, input logic [REPLAY_W-1:0] rep);
        record_backlog.push_back('{start, seq, t, data, pw, gen, wid, rep});
        stim_seq = seq;
        stim_time = t;
        stim_power = pw;
        stim_gen = gen;
        stim_width = wid;
        stim_replay = rep;
    endtask

    // Mostly plausible telemetry streams that follow the current period and spike limit,
    // with scan starts, lost records, late records, link changes and absent values mixed
    // in, plus a share of records with every field random.
    task automatic add_random_records(input int count);
        logic [SEQ_W-1:0]    seq;
        logic [TIME_W-1:0]   t;
        logic [POWER_W-1:0]  pw;
        logic [LINK_W-1:0]   gen;
        logic [LINK_W-1:0]   wid;
        logic [REPLAY_W-1:0] rep;
        logic                start;
        logic                data;
        int                  pick;
        int                  stride;
        for (int i = 0; i < count; i++)
        begin
            stride = int'(period_ticks);
            if ($urandom_range(99) < 10)
            begin
                add_rec(1'($urandom_range(1)), {$urandom, $urandom}, {$urandom, $urandom},
                        1'($urandom_range(1)), $urandom, 8'($urandom), 8'($urandom),
                        $urandom);
                continue;
            end
            start = ($urandom_range(99) < 3);
            data = ($urandom_range(99) < 85);

            pick = $urandom_range(99);
            if (start)
                seq = {$urandom, $urandom};
            else if (pick < 75)
                seq = stim_seq + 1;
            else if (pick < 87)
                seq = stim_seq + $urandom_range(2, 40);
            else if (pick < 93)
                seq = stim_seq - $urandom_range(0, 3);
            else
                seq = {$urandom, $urandom};

            // Intervals cluster around the hang threshold of three periods.
            pick = $urandom_range(99);
            if (start)
                t = {$urandom, $urandom};
            else if (pick < 65)
                t = stim_time + $urandom_range(1, 2 * stride);
            else if (pick < 85)
                t = stim_time + TIME_W'(HANG_FACTOR * stride) + $urandom_range(0, 2) - 1;
            else if (pick < 93)
                t = stim_time + ({$urandom, $urandom} >> $urandom_range(1, 40));
            else
                t = stim_time - $urandom_range(0, 1000);

            // Power changes cluster around the spike limit.
            pick = $urandom_range(99);
            if (pick < 40)
                pw = stim_power + $urandom_range(0, 2000) - 1000;
            else if (pick < 55)
                pw = stim_power + spike_limit + $urandom_range(0, 1);
            else if (pick < 62)
                pw = stim_power - spike_limit - $urandom_range(0, 1);
            else if (pick < 88)
                pw = $urandom;
            else
                pw = ABSENT32;

            pick = $urandom_range(99);
            if (pick < 65)
            begin
                gen = stim_gen;
                wid = stim_width;
            end
            else if (pick < 85)
            begin
                gen = 8'($urandom_range(1, 6));
                wid = 8'(1 << $urandom_range(0, 5));
            end
            else if (pick < 93)
            begin
                gen = 8'($urandom);
                wid = 8'($urandom);
            end
            else
            begin
                gen = $urandom_range(1) ? ABSENT8 : stim_gen;
                wid = $urandom_range(1) ? ABSENT8 : stim_width;
            end

            pick = $urandom_range(99);
            if (pick < 45)
                rep = stim_replay;
            else if (pick < 80)
                rep = stim_replay + $urandom_range(1, 50);
            else if (pick < 90)
                rep = $urandom;
            else
                rep = ABSENT_REPLAY;

            add_rec(start, seq, t, data, pw, gen, wid, rep);
        end
    endtask

    // Wait until every queued record has been taken and every report has come back, then
    // give the block time to finish any work that produces no report.
    task automatic wait_quiet();
        while (record_backlog.size() != 0 || push || expected_anomalies.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [ADDR_W-1:0] addr,
                                  input logic [DATA_W-1:0] value);
        wait_quiet();
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    initial
    begin
        logic [DATA_W-1:0] rate_plan  [NUM_PHASES];
        logic [DATA_W-1:0] limit_plan [NUM_PHASES];

        // Extreme rates and limits first, then one random setting.
        rate_plan  = '{0, 1000000, 1, 20'hFFFFF, $urandom_range(2, 200000)};
        limit_plan = '{0, 32'hFFFF_FFFF, DEFAULT_LIMIT, $urandom, $urandom_range(0, 5000)};

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed records under the reset configuration: period 1000000 ticks, so a hang
        // needs an interval above 3000000, and a spike limit of 100000 mW.
        // The first record after reset has nothing to compare with.
        add_rec(1'b0, 100, 1000, 1'b1, 5000, 4, 16, 10);
        add_rec(1'b0, 101, 1_001_000, 1'b1, 5000, 4, 16, 10);
        // All five anomalies at once.
        add_rec(1'b0, 105, 5_001_000, 1'b1, 205_001, 3, 16, 20);
        // Repeated sequence number, time going back, negative spike, width drop.
        add_rec(1'b0, 105, 4_000_000, 1'b1, 5000, 3, 8, 20);
        // Sequence going back; interval and power change exactly at their thresholds.
        add_rec(1'b0, 50, 7_000_000, 1'b1, 105_000, 3, 8, 19);
        // Both just above their thresholds.
        add_rec(1'b0, 51, 10_000_001, 1'b1, 205_001, 3, 8, 19);
        // Absent markers on the new record, then on the previous one.
        add_rec(1'b0, 52, 10_001_001, 1'b1, ABSENT32, ABSENT8, ABSENT8, ABSENT_REPLAY);
        add_rec(1'b0, 53, 10_002_001, 1'b1, 0, 1, 1, 0);
        // Largest present values against smallest, in both directions.
        add_rec(1'b0, 54, 10_003_001, 1'b1, 32'hFFFF_FFFE, 0, 0, 32'hFFFF_FFFE);
        add_rec(1'b0, 55, 10_004_001, 1'b1, 0, 254, 254, 0);
        // A non-data record suppresses the data checks on both sides of it.
        add_rec(1'b0, 56, 10_005_001, 1'b0, 900_000, 1, 1, 500);
        add_rec(1'b0, 57, 10_006_001, 1'b1, 0, 0, 0, 900);
        // Second gap of the scan.
        add_rec(1'b0, 60, 10_007_001, 1'b1, 0, 0, 0, 900);
        // New scan: no comparison, and the gap count starts over.
        add_rec(1'b1, 1000, 0, 1'b1, 0, 0, 0, 900);
        add_rec(1'b0, 1003, 100, 1'b1, 0, 0, 0, 900);
        // Sequence numbers at the top of the range and wrapping past it.
        add_rec(1'b0, 64'hFFFF_FFFF_FFFF_FFFE, 200, 1'b1, 0, 0, 0, 900);
        add_rec(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 300, 1'b1, 0, 0, 0, 900);
        add_rec(1'b0, 0, 400, 1'b1, 0, 0, 0, 900);
        add_rec(1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 500, 1'b1, 0, 0, 0, 900);
        add_rec(1'b0, 5, 600, 1'b1, 0, 0, 0, 900);
        // Timestamp at the top of the range, then back to zero.
        add_rec(1'b0, 6, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 0, 0, 0, 900);
        add_rec(1'b0, 7, 0, 1'b1, 0, 0, 0, 900);
        add_rec(1'b0, 8, 3_000_000, 1'b1, 0, 0, 0, 900);
        // Two scan starts in a row.
        add_rec(1'b1, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 0, 0, 0, 900);
        add_rec(1'b1, 64'h8000_0000_0000_0005, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 0, 0, 0, 900);

        // Random phases, each under its own configuration.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_register(RATE_ADDR, rate_plan[p]);
            write_register(LIMIT_ADDR, limit_plan[p]);
            add_random_records(ITEMS_PER_PHASE);
        end

        wait_quiet();
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Run limit, far above the slowest correct run.
    initial
    begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: telemetry_anomaly_monitor_unit.f
hdl/tam_pkg.sv
hdl/tam_period_div.sv
hdl/tam_front.sv
hdl/tam_queue.sv
hdl/tam_back.sv
hdl/telemetry_anomaly_monitor_unit.sv
hdl/tam_checker.sv
tb/telemetry_anomaly_monitor_unit_tb.sv
